[design/arpr_pkg.sv]
// Shared types, constants and reply-byte functions for the ARP request responder.
`default_nettype none
package arpr_pkg;

   localparam int MIN_FRAME_BYTES_DEF = 42;
   localparam int COUNT_W             = 6;
   localparam int MAC_W               = 48;
   localparam int IP_W                = 32;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_ADDR_W          = 4;

   localparam logic [COUNT_W-1:0] REPLY_LEN = 6'd42;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
   localparam logic [COUNT_W-1:0] REPLY_END = 6'd41;

   // Received frame byte positions
   localparam logic [COUNT_W-1:0] POS_TYPE_HI   = 6'd12;
   localparam logic [COUNT_W-1:0] POS_TYPE_LO   = 6'd13;
   localparam logic [COUNT_W-1:0] POS_OPER_HI   = 6'd20;
   localparam logic [COUNT_W-1:0] POS_OPER_LO   = 6'd21;
   localparam logic [COUNT_W-1:0] POS_SHA_FIRST = 6'd22;
   localparam logic [COUNT_W-1:0] POS_SPA_FIRST = 6'd28;
   localparam logic [COUNT_W-1:0] POS_THA_FIRST = 6'd32;
   localparam logic [COUNT_W-1:0] POS_TPA_FIRST = 6'd38;
   localparam logic [COUNT_W-1:0] POS_TPA_END   = 6'd42;
   localparam logic [COUNT_W-1:0] POS_SRC_FIRST = 6'd6;

   localparam logic [7:0] ETYPE_ARP_HI  = 8'h08;
   localparam logic [7:0] ETYPE_ARP_LO  = 8'h06;
   localparam logic [7:0] ETYPE_IP_HI   = 8'h08;
   localparam logic [7:0] ETYPE_IP_LO   = 8'h00;
   localparam logic [7:0] HTYPE_HI      = 8'h00;
   localparam logic [7:0] HTYPE_LO      = 8'h01;
   localparam logic [7:0] HLEN          = 8'h06;
   localparam logic [7:0] PLEN          = 8'h04;
   localparam logic [7:0] OPER_HI       = 8'h00;
   localparam logic [7:0] OPER_REQ_LO   = 8'h01;
   localparam logic [7:0] OPER_REPLY_LO = 8'h02;

   localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'hC0A8_0114;
   localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'h0;

   // Register index codes, taken from paddr[3]
   localparam logic REG_OWN_MAC = 1'b0;
   localparam logic REG_OWN_IP  = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_beat_type;

   typedef struct packed {
      logic             start;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  ip;
   } reply_start_type;

   function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] k);
      logic [5:0] sh;
      sh = {3'(3'd5 - k), 3'b000};
      return 8'(mac >> sh);
   endfunction

   function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip, input logic [1:0] k);
      logic [4:0] sh;
      sh = {2'(2'd3 - k), 3'b000};
      return 8'(ip >> sh);
   endfunction

   function automatic logic [7:0] reply_byte(input logic [COUNT_W-1:0] i,
                                             input logic [MAC_W-1:0]   req_mac,
                                             input logic [IP_W-1:0]    req_ip,
                                             input logic [MAC_W-1:0]   own_mac,
                                             input logic [IP_W-1:0]    own_ip);
      logic [7:0] b;
      b = 8'h00;
      if (i < POS_SRC_FIRST)
         b = mac_byte(req_mac, 3'(i));
      else if (i < POS_TYPE_HI)
         b = mac_byte(own_mac, 3'(i - POS_SRC_FIRST));
      else if (i < POS_SHA_FIRST) begin
         unique case (i)
            6'd12:   b = ETYPE_ARP_HI;
            6'd13:   b = ETYPE_ARP_LO;
            6'd14:   b = HTYPE_HI;
            6'd15:   b = HTYPE_LO;
            6'd16:   b = ETYPE_IP_HI;
            6'd17:   b = ETYPE_IP_LO;
            6'd18:   b = HLEN;
            6'd19:   b = PLEN;
            6'd20:   b = OPER_HI;
            6'd21:   b = OPER_REPLY_LO;
            default: b = 8'h00;
         endcase
      end
      else if (i < POS_SPA_FIRST)
         b = mac_byte(own_mac, 3'(i - POS_SHA_FIRST));
      else if (i < POS_THA_FIRST)
         b = ip_byte(own_ip, 2'(i - POS_SPA_FIRST));
      else if (i < POS_TPA_FIRST)
         b = mac_byte(req_mac, 3'(i - POS_THA_FIRST));
      else if (i < POS_TPA_END)
         b = ip_byte(req_ip, 2'(i - POS_TPA_FIRST));
      return b;
   endfunction

endpackage
`default_nettype wire

[design/arp_request_responder_core.sv]
// Top level of the ARP request responder: parser, reply generator and registers.
//
//   port group   direction  beat
//   req_*        in         one received frame byte and its last mark
//   rsp_*        out        one reply byte and its last mark
//   csr_*        in/out     APB-style access to own_mac (0x0) and own_ip (0x8)
//
// One received byte is taken per cycle. A matching frame's last byte starts a
// 42-beat reply, sent one beat per cycle from a registered output stage.
// While a reply is still being generated, only a frame's last byte is held off.
// Reset is synchronous; own_ip comes up as 192.168.1.20, own_mac as zero.
// rsp_stall holds the output register; received bytes keep flowing meanwhile.
`default_nettype none
module arp_request_responder_core #(
   parameter int MIN_FRAME_BYTES = arpr_pkg::MIN_FRAME_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire arpr_pkg::req_beat_type            req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output arpr_pkg::rsp_beat_type                 rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [arpr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [arpr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [arpr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   logic [arpr_pkg::MAC_W-1:0] own_mac;
   logic [arpr_pkg::IP_W-1:0]  own_ip;
   logic                       busy;
   logic                       beat_ok;
   arpr_pkg::reply_start_type  reply;

   assign req_stall = busy & req_valid & req_data.rx_last;
   assign beat_ok   = req_valid & ~req_stall;

   arpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .own_mac     (own_mac),
      .own_ip      (own_ip)
   );

   arpr_rx_parser #(
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_rx_parser (
      .clock   (clock),
      .reset   (reset),
      .beat_ok (beat_ok),
      .beat    (req_data),
      .own_ip  (own_ip),
      .reply   (reply)
   );

   arpr_tx_gen u_tx_gen (
      .clock     (clock),
      .reset     (reset),
      .reply     (reply),
      .own_mac   (own_mac),
      .own_ip    (own_ip),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[design/arpr_csr.sv]
// Configuration registers (own MAC and IP) behind an APB-style port.
`default_nettype none
module arpr_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [arpr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [arpr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [arpr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready,
   output logic      [arpr_pkg::MAC_W-1:0]         own_mac,
   output logic      [arpr_pkg::IP_W-1:0]          own_ip
);

   logic [arpr_pkg::MAC_W-1:0] own_mac_ff;
   logic [arpr_pkg::IP_W-1:0]  own_ip_ff;
   logic                       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= arpr_pkg::OWN_MAC_RESET;
         own_ip_ff  <= arpr_pkg::OWN_IP_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[3])
            arpr_pkg::REG_OWN_MAC: own_mac_ff <= csr_pwdata[arpr_pkg::MAC_W-1:0];
            arpr_pkg::REG_OWN_IP:  own_ip_ff  <= csr_pwdata[arpr_pkg::IP_W-1:0];
            default:               own_ip_ff  <= own_ip_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         arpr_pkg::REG_OWN_MAC: csr_prdata = 64'(own_mac_ff);
         arpr_pkg::REG_OWN_IP:  csr_prdata = 64'(own_ip_ff);
         default:               csr_prdata = '0;
      endcase
   end

   assign own_mac = own_mac_ff;
   assign own_ip  = own_ip_ff;

endmodule
`default_nettype wire

[design/arpr_rx_parser.sv]
// Received frame parser: byte count, header checks and requester capture.
`default_nettype none
module arpr_rx_parser #(
   parameter int MIN_FRAME_BYTES = arpr_pkg::MIN_FRAME_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          beat_ok,
   input  wire arpr_pkg::req_beat_type        beat,
   input  wire logic [arpr_pkg::IP_W-1:0]     own_ip,
   output arpr_pkg::reply_start_type          reply
);

   localparam logic [arpr_pkg::COUNT_W-1:0] MIN_BYTES = arpr_pkg::COUNT_W'(MIN_FRAME_BYTES);

   logic [arpr_pkg::COUNT_W-1:0] count_ff,  count_in, total;
   logic [arpr_pkg::MAC_W-1:0]   req_mac_ff, req_mac_in;
   logic [arpr_pkg::IP_W-1:0]    req_ip_ff,  req_ip_in;
   logic type_ok_ff,   type_ok_in;
   logic opcode_ok_ff, opcode_ok_in;
   logic target_ok_ff, target_ok_in;
   logic match;

   always_comb begin
      type_ok_in   = type_ok_ff;
      opcode_ok_in = opcode_ok_ff;
      target_ok_in = target_ok_ff;
      req_mac_in   = req_mac_ff;
      req_ip_in    = req_ip_ff;
      priority if (count_ff == arpr_pkg::POS_TYPE_HI)
         type_ok_in = (beat.rx_byte == arpr_pkg::ETYPE_ARP_HI);
      else if (count_ff == arpr_pkg::POS_TYPE_LO)
         type_ok_in = type_ok_ff & (beat.rx_byte == arpr_pkg::ETYPE_ARP_LO);
      else if (count_ff == arpr_pkg::POS_OPER_HI)
         opcode_ok_in = (beat.rx_byte == arpr_pkg::OPER_HI);
      else if (count_ff == arpr_pkg::POS_OPER_LO)
         opcode_ok_in = opcode_ok_ff & (beat.rx_byte == arpr_pkg::OPER_REQ_LO);
      else if (count_ff >= arpr_pkg::POS_SHA_FIRST && count_ff < arpr_pkg::POS_SPA_FIRST)
         req_mac_in = {req_mac_ff[arpr_pkg::MAC_W-9:0], beat.rx_byte};
      else if (count_ff >= arpr_pkg::POS_SPA_FIRST && count_ff < arpr_pkg::POS_THA_FIRST)
         req_ip_in = {req_ip_ff[arpr_pkg::IP_W-9:0], beat.rx_byte};
      else if (count_ff == arpr_pkg::POS_TPA_FIRST)
         target_ok_in = (beat.rx_byte == arpr_pkg::ip_byte(own_ip, 2'd0));
      else if (count_ff > arpr_pkg::POS_TPA_FIRST && count_ff < arpr_pkg::POS_TPA_END)
         target_ok_in = target_ok_ff & (beat.rx_byte ==
                        arpr_pkg::ip_byte(own_ip, 2'(count_ff - arpr_pkg::POS_TPA_FIRST)));
      else
         type_ok_in = type_ok_ff;

      total = (count_ff < arpr_pkg::COUNT_MAX) ? 6'(count_ff + 6'd1) : arpr_pkg::COUNT_MAX;
      count_in = total;
      match = (total >= MIN_BYTES) && (total >= arpr_pkg::REPLY_LEN)
              && type_ok_in && opcode_ok_in && target_ok_in;

      // Frame end: drop every flag so nothing carries into the next frame
      if (beat.rx_last) begin
         count_in     = '0;
         type_ok_in   = 1'b0;
         opcode_ok_in = 1'b0;
         target_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         type_ok_ff   <= 1'b0;
         opcode_ok_ff <= 1'b0;
         target_ok_ff <= 1'b0;
         req_mac_ff   <= '0;
         req_ip_ff    <= '0;
      end else if (beat_ok) begin
         count_ff     <= count_in;
         type_ok_ff   <= type_ok_in;
         opcode_ok_ff <= opcode_ok_in;
         target_ok_ff <= target_ok_in;
         req_mac_ff   <= req_mac_in;
         req_ip_ff    <= req_ip_in;
      end
   end

   assign reply.start = beat_ok & beat.rx_last & match;
   assign reply.mac   = req_mac_in;
   assign reply.ip    = req_ip_in;

endmodule
`default_nettype wire

[design/arpr_tx_gen.sv]
// Reply generator: walks the 42 reply bytes into the output register.
`default_nettype none
module arpr_tx_gen (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire arpr_pkg::reply_start_type     reply,
   input  wire logic [arpr_pkg::MAC_W-1:0]    own_mac,
   input  wire logic [arpr_pkg::IP_W-1:0]     own_ip,
   output logic                               busy,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output arpr_pkg::rsp_beat_type             rsp_data
);

   logic                         busy_ff;
   logic [arpr_pkg::COUNT_W-1:0] idx_ff;
   logic [arpr_pkg::MAC_W-1:0]   mac_ff;
   logic [arpr_pkg::IP_W-1:0]    ip_ff;
   logic                         out_valid_ff;
   arpr_pkg::rsp_beat_type       out_ff, out_in;
   logic                         out_load;

   assign out_load       = ~out_valid_ff | ~rsp_stall;
   assign out_in.tx_byte = arpr_pkg::reply_byte(idx_ff, mac_ff, ip_ff, own_mac, own_ip);
   assign out_in.tx_last = (idx_ff == arpr_pkg::REPLY_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= busy_ff;
            if (busy_ff) begin
               idx_ff <= 6'(idx_ff + 6'd1);
               if (out_in.tx_last)
                  busy_ff <= 1'b0;
            end
         end
         // Upstream holds the last beat while busy, so start never meets a live reply
         if (reply.start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reply.start) begin
         mac_ff <= reply.mac;
         ip_ff  <= reply.ip;
      end
      if (out_load && busy_ff)
         out_ff <= out_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the ARP request responder core.
`default_nettype none
module tb;
   import arpr_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int MIN_LEN    = MIN_FRAME_BYTES_DEF;
   localparam int PHASE_ITEMS = 42;

   localparam logic [15:0] ETHERTYPE_ARP  = {ETYPE_ARP_HI, ETYPE_ARP_LO};
   localparam logic [15:0] ETHERTYPE_IP   = {ETYPE_IP_HI, ETYPE_IP_LO};
   localparam logic [15:0] OPCODE_REQUEST = {OPER_HI, OPER_REQ_LO};
   localparam logic [15:0] OPCODE_REPLY   = {OPER_HI, OPER_REPLY_LO};

   typedef enum logic {WANT_NONE, WANT_MODEL} want_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   typedef struct {
      int          len;
      logic [15:0] etype;
      logic [15:0] oper;
      logic [47:0] sha;
      logic [31:0] spa;
      logic [31:0] tpa;
      logic [7:0]  fill;
      bit          rand_fill;
      bit          noise;
      want_type    want;
   } frame_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_beat_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   arp_request_responder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the registers and of the parser state
   logic [47:0]  cfg_mac;
   logic [31:0]  cfg_ip;
   logic [5:0]   frame_pos;
   logic [47:0]  pred_mac;
   logic [31:0]  pred_ip;
   logic         type_match;
   logic         oper_match;
   logic         tpa_match;

   rsp_beat_type reply_beats_q[$];
   rsp_beat_type oldest;
   bit           keep_reply;
   int           err_count;
   int           rx_beats;
   int           beats_checked;
   int           replies_due;
   int           frames_sent;
   int           burst_left;
   int           stall_left;
   stall_mode_type stall_mode;
   int           idle_cycles;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;
   wire csr_fire = csr_psel && csr_penable && csr_pwrite && csr_pready;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      if (err_count < 40)
         $display("tb: mismatch: %s", msg);
      err_count++;
   endtask

   // Advance the parser copy by one received byte; queue the reply on a passing frame end
   function automatic void predict_rx(input req_beat_type beat, input bit keep);
      logic [7:0]   b;
      logic [5:0]   pos;
      logic [335:0] reply;
      rsp_beat_type e;
      int           sh;
      b   = beat.rx_byte;
      pos = frame_pos;
      if (pos == POS_TYPE_HI)
         type_match = (b == ETYPE_ARP_HI);
      else if (pos == POS_TYPE_LO)
         type_match = type_match && (b == ETYPE_ARP_LO);
      else if (pos == POS_OPER_HI)
         oper_match = (b == OPER_HI);
      else if (pos == POS_OPER_LO)
         oper_match = oper_match && (b == OPER_REQ_LO);
      else if (pos >= POS_SHA_FIRST && pos < POS_SPA_FIRST)
         pred_mac = {pred_mac[39:0], b};
      else if (pos >= POS_SPA_FIRST && pos < POS_THA_FIRST)
         pred_ip = {pred_ip[23:0], b};
      else if (pos >= POS_TPA_FIRST && pos < POS_TPA_END) begin
         sh = 8 * (41 - int'(pos));
         tpa_match = (pos == POS_TPA_FIRST || tpa_match) && (b == cfg_ip[sh +: 8]);
      end
      if (pos != COUNT_MAX)
         pos = pos + 6'd1;
      frame_pos = pos;
      if (beat.rx_last) begin
         if (int'(pos) >= MIN_LEN && pos >= REPLY_LEN && type_match && oper_match
             && tpa_match && keep) begin
            reply = {pred_mac, cfg_mac, ETHERTYPE_ARP, HTYPE_HI, HTYPE_LO, ETHERTYPE_IP,
                     HLEN, PLEN, OPCODE_REPLY, cfg_mac, cfg_ip, pred_mac, pred_ip};
            for (int k = 0; k < 42; k++) begin
               e = {reply[335 - 8*k -: 8], 1'(k == 41)};
               reply_beats_q.push_back(e);
            end
            replies_due++;
         end
         frame_pos  = '0;
         type_match = 1'b0;
         oper_match = 1'b0;
         tpa_match  = 1'b0;
      end
   endfunction

   function automatic frame_row_type make_row(input int len, input logic [15:0] etype,
                                              input logic [15:0] oper, input logic [47:0] sha,
                                              input logic [31:0] spa, input logic [31:0] tpa,
                                              input logic [7:0] fill, input bit rand_fill,
                                              input bit noise, input want_type want);
      frame_row_type f;
      f.len = len;
      f.etype = etype;
      f.oper = oper;
      f.sha = sha;
      f.spa = spa;
      f.tpa = tpa;
      f.fill = fill;
      f.rand_fill = rand_fill;
      f.noise = noise;
      f.want = want;
      return f;
   endfunction

   function automatic logic [7:0] frame_byte(input frame_row_type f, input int i);
      logic [47:0] hdr;
      logic [7:0]  pad;
      hdr = {HTYPE_HI, HTYPE_LO, ETYPE_IP_HI, ETYPE_IP_LO, HLEN, PLEN};
      pad = f.rand_fill ? 8'($urandom_range(0, 255)) : f.fill;
      if (f.noise)
         return 8'($urandom_range(0, 255));
      if (i < 6)  return pad;
      if (i < 12) return f.sha[8*(11 - i) +: 8];
      if (i < 14) return f.etype[8*(13 - i) +: 8];
      if (i < 20) return f.rand_fill ? pad : hdr[8*(19 - i) +: 8];
      if (i < 22) return f.oper[8*(21 - i) +: 8];
      if (i < 28) return f.sha[8*(27 - i) +: 8];
      if (i < 32) return f.spa[8*(31 - i) +: 8];
      if (i < 38) return pad;
      if (i < 42) return f.tpa[8*(41 - i) +: 8];
      return pad;
   endfunction

   // Drive one frame in bursts; each beat holds until accepted
   task automatic drive_frame(input frame_row_type f);
      keep_reply = (f.want == WANT_MODEL);
      for (int i = 0; i < f.len; i++) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
         end
         req_valid <= 1'b1;
         req_data  <= {frame_byte(f, i), 1'(i == f.len - 1)};
         do @(posedge clock); while (req_stall);
         @(negedge clock);
         burst_left--;
      end
      frames_sent++;
   endtask

   task automatic write_reg(input logic reg_code, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_code, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_code == REG_OWN_MAC)
         cfg_mac = value[47:0];
      else
         cfg_ip = value[31:0];
   endtask

   // Drop valid, drain the outstanding reply beats, then let the core go quiet
   task automatic settle(input int pause);
      req_valid <= 1'b0;
      while (reply_beats_q.size() != 0) @(posedge clock);
      repeat (pause) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && req_fire) begin
         predict_rx(req_data, keep_reply);
         rx_beats++;
      end
      if (!reset && rsp_fire) begin
         if (reply_beats_q.size() == 0) begin
            report($sformatf("reply beat %02h/%0b with nothing expected",
                             rsp_data.tx_byte, rsp_data.tx_last));
         end else begin
            oldest = reply_beats_q.pop_front();
            if (rsp_data.tx_byte !== oldest.tx_byte)
               report($sformatf("beat %0d tx_byte %02h, want %02h",
                                beats_checked, rsp_data.tx_byte, oldest.tx_byte));
            if (rsp_data.tx_last !== oldest.tx_last)
               report($sformatf("beat %0d tx_last %0b, want %0b",
                                beats_checked, rsp_data.tx_last, oldest.tx_last));
            beats_checked++;
         end
      end
   end

   // Receiver stalls follow modes of random length
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   // Only expected reply beats count as progress, so a runaway output still ends the run
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || csr_fire || (rsp_fire && reply_beats_q.size() != 0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: watchdog expired with %0d reply beats outstanding", reply_beats_q.size());
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      frame_row_type directed_q[$];
      frame_row_type f;
      logic [31:0] rst_ip;
      logic [47:0] mac_v;
      logic [31:0] ip_v;
      int          phase_items;
      int          kind;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_mac     = OWN_MAC_RESET;
      cfg_ip      = OWN_IP_RESET;
      frame_pos   = '0;
      pred_mac    = '0;
      pred_ip     = '0;
      type_match  = 1'b0;
      oper_match  = 1'b0;
      tpa_match   = 1'b0;
      keep_reply  = 1'b1;
      err_count   = 0;
      rx_beats    = 0;
      beats_checked = 0;
      replies_due = 0;
      frames_sent = 0;
      burst_left  = 0;
      stall_left  = 0;
      stall_mode  = STALL_NONE;
      rst_ip      = OWN_IP_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames, all at the reset register values
      directed_q.push_back(make_row(42, ETHERTYPE_ARP, OPCODE_REQUEST, 48'h0200_0000_0001,
                                    32'h0A00_0001, rst_ip, 8'h00, 0, 0, WANT_MODEL));
      // Back to back requests: the second last byte may meet the first reply still going out
      directed_q.push_back(make_row(42, ETHERTYPE_ARP, OPCODE_REQUEST, '1, '1, rst_ip,
                                    8'hFF, 0, 0, WANT_MODEL));
      directed_q.push_back(make_row(41, ETHERTYPE_ARP, OPCODE_REQUEST, 48'h0200_0000_0002,
                                    32'h0A00_0002, rst_ip, 8'h00, 0, 0, WANT_NONE));
      directed_q.push_back(make_row(1, ETHERTYPE_ARP, OPCODE_REQUEST, '0, '0, rst_ip,
                                    8'hFF, 0, 0, WANT_NONE));
      directed_q.push_back(make_row(42, ETHERTYPE_ARP, 16'h0101, 48'h0200_0000_0003,
                                    32'h0A00_0003, rst_ip, 8'h00, 0, 0, WANT_NONE));

      foreach (directed_q[r])
         drive_frame(directed_q[r]);

      for (int ph = 0; ph < 2; ph++) begin
         settle(8);
         case (ph)
            0: begin
               mac_v = {16'($urandom), 32'($urandom)};
               ip_v  = 32'($urandom);
            end
            default: begin
               mac_v = '1;
               ip_v  = '1;
            end
         endcase
         // Upper data bits carry junk that the registers must drop
         write_reg(REG_OWN_MAC, {16'($urandom), mac_v});
         write_reg(REG_OWN_IP, {32'($urandom), ip_v});

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            f = make_row(($urandom_range(0, 9) < 7) ? 42 : $urandom_range(43, 60),
                         ETHERTYPE_ARP, OPCODE_REQUEST, {16'($urandom), 32'($urandom)},
                         32'($urandom), cfg_ip, 8'($urandom), $urandom_range(0, 1), 0,
                         WANT_MODEL);
            if (kind >= 55 && kind < 62)
               f.etype = f.etype ^ (16'h1 << $urandom_range(0, 15));
            else if (kind >= 62 && kind < 69)
               f.oper = f.oper ^ (16'h1 << $urandom_range(0, 15));
            else if (kind >= 69 && kind < 78)
               f.tpa = f.tpa ^ (32'h1 << $urandom_range(0, 31));
            else if (kind >= 78 && kind < 86)
               f.len = $urandom_range(1, 41);
            else if (kind >= 86 && kind < 93)
               f.len = $urandom_range(61, 80);
            else if (kind >= 93) begin
               f.noise = 1;
               f.len   = $urandom_range(1, 80);
            end
            drive_frame(f);
            phase_items += f.len;
         end
      end

      settle(20);
      $display("tb: %0d frames, %0d received bytes, %0d replies, %0d reply beats checked",
               frames_sent, rx_beats, replies_due, beats_checked);
      $display("tb: registers at reset, random and all ones; short, long, %s",
               "broken and noise frames under bursty input and output stalls");
      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
design/arpr_pkg.sv
design/arpr_csr.sv
design/arpr_rx_parser.sv
design/arpr_tx_gen.sv
design/arp_request_responder_core.sv
sim/tb.sv
